### hw/rtl/access_point_table_aging_unit_assert.svh
// Assertion macros for the access point table aging unit.
`ifndef ACCESS_POINT_TABLE_AGING_UNIT_ASSERT_SVH
`define ACCESS_POINT_TABLE_AGING_UNIT_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define APT_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define APT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### hw/rtl/apt_pkg.sv
// Shared types and constants for the access point table aging unit.
package apt_pkg;

    localparam logic [15:0] AGE_LIMIT_RESET = 16'd30;
    localparam logic [1:0]  FTYPE_MGMT      = 2'd0;
    localparam logic [3:0]  FSUB_BEACON     = 4'd8;

    // One table record as stored in the record memory.
    typedef struct packed {
        logic [47:0] mac;
        logic [31:0] seen_time;
        logic [31:0] tx;
        logic [31:0] rx;
        logic [31:0] beacons;
        logic [15:0] freq;
    } apt_rec_t;

    localparam int REC_W = $bits(apt_rec_t);

endpackage

### hw/rtl/access_point_table_aging_unit.sv
// Top level of the access point table aging unit.
//
// channel | direction | handshake       | contents
// in      | input     | in_valid/ready  | op, now_seconds, bssid, flags, type, channel
// out     | output    | out_valid/ready | hit/insert/drop flags, counts, totals
// cfg     | input     | cfg_we          | age_limit_seconds
//
// Each item walks the table one slot per cycle through the record memory read
// port. An age sweep walks every slot before it gives its result; a frame stops
// at a hit or at the end on a miss, then rereads its slot and writes it unless full.
// Valid bits and counters clear at reset; the record memory needs no clearing.
// One item is in work at a time; the result sits in an output register, and
// the next request is taken as soon as that register is free.
module access_point_table_aging_unit #(
    parameter int TABLE_ENTRIES = 128
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        op,
    input  logic [31:0] now_seconds,
    input  logic [47:0] bssid,
    input  logic        from_ds,
    input  logic        to_ds,
    input  logic [1:0]  frame_type,
    input  logic [3:0]  frame_subtype,
    input  logic [15:0] channel_mhz,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        hit,
    output logic        inserted,
    output logic        dropped_full,
    output logic [7:0]  entry_count,
    output logic [31:0] tx_total,
    output logic [31:0] rx_total,
    output logic [31:0] beacon_total,
    output logic [7:0]  evicted,
    output logic [31:0] frame_total
);
    import apt_pkg::*;
    `include "access_point_table_aging_unit_assert.svh"

    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam int CW = $clog2(TABLE_ENTRIES + 1);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SCAN = 4'b0010,
        ST_RD   = 4'b0100,
        ST_WR   = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [15:0] age_limit_reg;
    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic [CW-1:0] count_reg;
    logic [31:0] frames_reg;

    // latched request
    logic        op_reg;
    logic [31:0] now_reg;
    logic [47:0] mac_reg;
    logic        from_reg, to_reg, beacon_reg;
    logic [15:0] freq_reg;

    // scan bookkeeping
    logic [AW:0]   raddr_cnt_reg;   // next read address
    logic [AW:0]   chk_cnt_reg;     // address of data now on the read port
    logic          chk_vld_reg;
    logic          found_reg;
    logic [AW-1:0] slot_reg;
    logic [CW-1:0] evict_cnt_reg;

    // output register
    logic        ov_reg;
    logic        o_hit_reg, o_ins_reg, o_drop_reg;
    logic [7:0]  o_cnt_reg, o_evict_reg;
    logic [31:0] o_tx_reg, o_rx_reg, o_bc_reg, o_fr_reg;

    // memory ports
    logic          mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    apt_rec_t      mem_wdata, mem_rdata;

    apt_ram #(.WIDTH(REC_W), .DEPTH(TABLE_ENTRIES)) u_rec_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    logic in_fire;
    assign in_fire  = in_valid && in_ready;
    assign in_ready = (state_reg == ST_IDLE) && !ov_reg;

    // per-slot checks on the data returned by the read port
    logic [AW-1:0] chk_idx;
    logic          chk_live, chk_match, chk_old;
    logic [31:0]   age_diff;
    assign chk_idx   = chk_cnt_reg[AW-1:0];
    assign chk_live  = chk_vld_reg && valid_reg[chk_idx];
    assign chk_match = chk_live && (mem_rdata.mac == mac_reg);
    assign age_diff  = now_reg - mem_rdata.seen_time;
    assign chk_old   = chk_live && (now_reg > mem_rdata.seen_time)
                       && (age_diff > {16'd0, age_limit_reg});

    // first free slot, found by priority over the valid bits
    logic          free_any;
    logic [AW-1:0] free_idx;
    always_comb
    begin
        free_any = 1'b0;
        free_idx = '0;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_any = 1'b1;
                free_idx = AW'(i);
            end
        end
    end

    logic scan_done;
    assign scan_done = chk_vld_reg && (chk_cnt_reg == (AW+1)'(TABLE_ENTRIES - 1));

    // updated record for the chosen slot
    apt_rec_t rec_new;
    always_comb
    begin
        rec_new = mem_rdata;
        if (!found_reg)
        begin
            rec_new = '0;
            rec_new.mac = mac_reg;
        end
        if (from_reg)
        begin
            rec_new.seen_time = now_reg;
            rec_new.tx = rec_new.tx + 32'd1;
        end
        if (to_reg)
        begin
            rec_new.rx = rec_new.rx + 32'd1;
        end
        if (beacon_reg)
        begin
            rec_new.seen_time = now_reg;
            rec_new.beacons = rec_new.beacons + 32'd1;
            rec_new.freq = freq_reg;
        end
    end

    // control
    always_comb
    begin
        state_next = state_reg;
        mem_raddr  = raddr_cnt_reg[AW-1:0];
        mem_we     = 1'b0;
        mem_waddr  = slot_reg;
        mem_wdata  = rec_new;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (op_reg ? scan_done : (chk_match || scan_done))
                begin
                    state_next = op_reg ? ST_IDLE : ST_RD;
                end
            end
            ST_RD:
            begin
                mem_raddr  = slot_reg;
                state_next = ST_WR;
            end
            ST_WR:
            begin
                mem_we     = found_reg || free_any;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            age_limit_reg <= AGE_LIMIT_RESET;
            valid_reg     <= '0;
            count_reg     <= '0;
            frames_reg    <= '0;
            ov_reg        <= 1'b0;
            raddr_cnt_reg <= '0;
            chk_cnt_reg   <= '0;
            chk_vld_reg   <= 1'b0;
            found_reg     <= 1'b0;
            evict_cnt_reg <= '0;
            o_hit_reg     <= 1'b0;
            o_ins_reg     <= 1'b0;
            o_drop_reg    <= 1'b0;
            o_cnt_reg     <= '0;
            o_evict_reg   <= '0;
            o_tx_reg      <= '0;
            o_rx_reg      <= '0;
            o_bc_reg      <= '0;
            o_fr_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                age_limit_reg <= cfg_wdata;
            end
            if (out_valid && out_ready)
            begin
                ov_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        raddr_cnt_reg <= '0;
                        chk_vld_reg   <= 1'b0;
                        found_reg     <= 1'b0;
                        evict_cnt_reg <= '0;
                        if (!op)
                        begin
                            frames_reg <= frames_reg + 32'd1;
                        end
                    end
                end
                ST_SCAN:
                begin
                    // walk addresses; read data arrives on the cycle after its address
                    if (raddr_cnt_reg != (AW+1)'(TABLE_ENTRIES))
                    begin
                        raddr_cnt_reg <= raddr_cnt_reg + 1'b1;
                    end
                    chk_cnt_reg <= raddr_cnt_reg;
                    chk_vld_reg <= raddr_cnt_reg != (AW+1)'(TABLE_ENTRIES);
                    if (op_reg && chk_old)
                    begin
                        valid_reg[chk_idx] <= 1'b0;
                        evict_cnt_reg      <= evict_cnt_reg + 1'b1;
                    end
                    if (!op_reg && chk_match)
                    begin
                        found_reg <= 1'b1;
                    end
                    if (op_reg && scan_done)
                    begin
                        ov_reg      <= 1'b1;
                        o_hit_reg   <= 1'b0;
                        o_ins_reg   <= 1'b0;
                        o_drop_reg  <= 1'b0;
                        o_tx_reg    <= '0;
                        o_rx_reg    <= '0;
                        o_bc_reg    <= '0;
                        o_fr_reg    <= frames_reg;
                        count_reg   <= count_reg - (evict_cnt_reg + CW'(chk_old));
                        o_cnt_reg   <= 8'(count_reg - (evict_cnt_reg + CW'(chk_old)));
                        o_evict_reg <= 8'(evict_cnt_reg + CW'(chk_old));
                    end
                end
                ST_WR:
                begin
                    ov_reg      <= 1'b1;
                    o_hit_reg   <= found_reg;
                    o_ins_reg   <= !found_reg && free_any;
                    o_drop_reg  <= !found_reg && !free_any;
                    o_evict_reg <= '0;
                    o_fr_reg    <= frames_reg;
                    if (found_reg || free_any)
                    begin
                        o_tx_reg <= rec_new.tx;
                        o_rx_reg <= rec_new.rx;
                        o_bc_reg <= rec_new.beacons;
                    end
                    else
                    begin
                        o_tx_reg <= '0;
                        o_rx_reg <= '0;
                        o_bc_reg <= '0;
                    end
                    if (!found_reg && free_any)
                    begin
                        valid_reg[slot_reg] <= 1'b1;
                        count_reg <= count_reg + 1'b1;
                        o_cnt_reg <= 8'(count_reg + 1'b1);
                    end
                    else
                    begin
                        o_cnt_reg <= 8'(count_reg);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // slot index: the matching address, or the first free slot on a miss
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_SCAN && !op_reg && chk_match)
        begin
            slot_reg <= chk_idx;
        end
        if (state_reg == ST_RD && !found_reg)
        begin
            slot_reg <= free_idx;
        end
        if (in_fire)
        begin
            op_reg     <= op;
            now_reg    <= now_seconds;
            mac_reg    <= bssid;
            from_reg   <= from_ds;
            to_reg     <= to_ds;
            beacon_reg <= (frame_type == FTYPE_MGMT) && (frame_subtype == FSUB_BEACON);
            freq_reg   <= channel_mhz;
        end
    end

    assign out_valid    = ov_reg;
    assign hit          = o_hit_reg;
    assign inserted     = o_ins_reg;
    assign dropped_full = o_drop_reg;
    assign entry_count  = o_cnt_reg;
    assign tx_total     = o_tx_reg;
    assign rx_total     = o_rx_reg;
    assign beacon_total = o_bc_reg;
    assign evicted      = o_evict_reg;
    assign frame_total  = o_fr_reg;

    `APT_ASSERT_IMP(a_count_range, 1'b1, count_reg <= CW'(TABLE_ENTRIES))
    `APT_ASSERT_IMP(a_flags_excl, out_valid,
        $countones({o_hit_reg, o_ins_reg, o_drop_reg}) <= 1)
    `APT_ASSERT_IMP(a_write_only_wr, mem_we, state_reg == ST_WR)
    `APT_ASSERT_NEXT(a_wr_gives_result, state_reg == ST_WR, ov_reg)
endmodule

### hw/rtl/apt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module apt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
